// ----- hw/rtl/mmn_pkg.sv -----
// mmn_pkg: shared widths, constants and types for the min-max normalizer
// used by mmn_store, mmn_divider and minmax_normalize
package mmn_pkg;

   localparam int DEPTH       = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_BITS   = $clog2(DEPTH + 1);
   localparam int SCALE_BITS  = 16;
   localparam int POS_BITS    = 6;
   localparam int SPAN_BITS   = SAMPLE_BITS;
   localparam int NUM_BITS    = SPAN_BITS + SCALE_BITS;
   localparam int STEP_BITS   = $clog2(SCALE_BITS);

   localparam logic [SCALE_BITS-1:0] FULL_SCALE = {SCALE_BITS{1'b1}};

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- hw/rtl/minmax_normalize.sv -----
// minmax_normalize: min-max normalization of a sample set, top level
// depends on mmn_pkg, mmn_store and mmn_divider
// loading: one sample transaction per cycle, rsp side idle
// emit: each result passes memory read, operand setup, 16-step serial divide, done and
// output register; a flat set skips the divide
// input is not accepted during the emit run; sync reset clears the set, memory is not cleared
module minmax_normalize
   import mmn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tlast,   // final_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] scaled_value, [21:16] position, zero pad
   output logic        rsp_tlast,   // run_end
   output logic [1:0]  rsp_tuser    // [0] flat_range, [1] overflowed
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_SEND  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [FILL_BITS-1:0]          fill_ff, fill_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic                          drop_ff, drop_in;
   logic [ADDR_BITS-1:0]          idx_ff, idx_in;
   logic                          valid_ff, valid_in;
   logic [SCALE_BITS-1:0]         scaled_ff, scaled_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic                          end_ff, end_in;
   logic                          flat_ff, flat_in;
   logic                          ovf_ff, ovf_in;

   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          req_take;
   logic                          rsp_take;
   logic                          store_wr;
   logic                          store_rd;
   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic [SAMPLE_BITS:0]          span_wide;
   logic [SPAN_BITS-1:0]          span;
   logic                          flat;
   logic [SAMPLE_BITS:0]          diff_wide;
   logic [NUM_BITS-1:0]           numer;
   logic                          div_start;
   logic [SCALE_BITS-1:0]         quotient;
   div_status_type                div_status;
   logic                          idx_last;

   assign sample   = req_tdata[SAMPLE_BITS-1:0];
   assign req_take = req_tvalid && req_tready;
   assign rsp_take = valid_ff && rsp_tready;
   assign store_wr = req_take && (fill_ff < FILL_BITS'(DEPTH));
   assign store_rd = (state_ff == S_READ);

   assign span_wide = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign span      = span_wide[SPAN_BITS-1:0];
   assign flat      = (span == '0);
   assign diff_wide = {rd_data[SAMPLE_BITS-1], rd_data} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign numer     = {diff_wide[SPAN_BITS-1:0], {SCALE_BITS{1'b0}}}
                      - {{SCALE_BITS{1'b0}}, diff_wide[SPAN_BITS-1:0]};
   assign div_start = (state_ff == S_START) && !flat;
   assign idx_last  = ({1'b0, idx_ff} + 1'b1) == (ADDR_BITS + 1)'(fill_ff);

   mmn_store u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (fill_ff[ADDR_BITS-1:0]),
      .wr_data (sample),
      .rd_en   (store_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   mmn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer),
      .divisor  (span),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      drop_in   = drop_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      scaled_in = scaled_ff;
      pos_in    = pos_ff;
      end_in    = end_ff;
      flat_in   = flat_ff;
      ovf_in    = ovf_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_take) begin
               if (store_wr) begin
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff == '0) begin
                     min_in = sample;
                     max_in = sample;
                  end else begin
                     if (sample < min_ff) min_in = sample;
                     if (sample > max_ff) max_in = sample;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  idx_in   = '0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_START;
         end
         S_START: begin
            pos_in  = POS_BITS'(idx_ff);
            end_in  = idx_last;
            flat_in = flat;
            ovf_in  = drop_ff;
            if (flat) begin
               scaled_in = '0;
               valid_in  = 1'b1;
               state_in  = S_SEND;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               scaled_in = quotient;
               valid_in  = 1'b1;
               state_in  = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_take) begin
               valid_in = 1'b0;
               if (end_ff) begin
                  fill_in  = '0;
                  min_in   = '0;
                  max_in   = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fill_ff  <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         drop_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         drop_ff  <= drop_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      pos_ff    <= pos_in;
      end_ff    <= end_in;
      flat_ff   <= flat_in;
      ovf_ff    <= ovf_in;
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, pos_ff, scaled_ff};
   assign rsp_tlast  = end_ff;
   assign rsp_tuser  = {ovf_ff, flat_ff};

endmodule

// ----- hw/rtl/mmn_store.sv -----
// mmn_store: sample memory, one write port and one registered read port
// depends on mmn_pkg
module mmn_store
   import mmn_pkg::*;
(
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_BITS-1:0]          wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_BITS-1:0]          rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);

   logic signed [SAMPLE_BITS-1:0] mem_ff [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mmn_divider.sv -----
// mmn_divider: bit-serial restoring divider, one quotient bit per cycle
// depends on mmn_pkg; quotient must fit in SCALE_BITS bits
module mmn_divider
   import mmn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_BITS-1:0]   dividend,
   input  logic [SPAN_BITS-1:0]  divisor,
   output logic [SCALE_BITS-1:0] quotient,
   output div_status_type        status
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [SPAN_BITS-1:0]  rem_ff, rem_in;
   logic [SCALE_BITS-1:0] low_ff, low_in;
   logic [SCALE_BITS-1:0] quo_ff, quo_in;
   logic [SPAN_BITS-1:0]  div_ff, div_in;
   logic [SPAN_BITS:0]    trial;
   logic [SPAN_BITS:0]    diff;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SCALE_BITS - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, low_ff[SCALE_BITS-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[NUM_BITS-1:SCALE_BITS];
         low_in  = dividend[SCALE_BITS-1:0];
         div_in  = divisor;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         low_in  = {low_ff[SCALE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[SPAN_BITS-1:0];
            quo_in = {quo_ff[SCALE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[SPAN_BITS-1:0];
            quo_in = {quo_ff[SCALE_BITS-2:0], 1'b0};
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
